// ----- hw/rtl/tse_pkg.sv -----
// Shared constants, field widths, operation codes and types of the text screen edit engine.
// Used by the top level, the sequencer and the checker; depends on nothing else.
package tse_pkg;

   // Screen geometry.
   localparam int COLUMNS = 32;
   localparam int ROWS    = 16;

   // Internal widths that follow from the geometry.
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int CNT_W  = ROW_W + 1;
   localparam int DEPTH  = 1 << ADDR_W;

   // Transaction field widths.
   localparam int OP_W      = 3;
   localparam int IN_ROW_W  = 4;
   localparam int IN_COL_W  = 5;
   localparam int MODE_W    = 2;
   localparam int IN_CNT_W  = 5;
   localparam int CELL_W    = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // Blank character.
   localparam logic [CELL_W-1:0] BLANK = 8'h20;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE      = 3'd0;
   localparam logic [OP_W-1:0] OP_READ       = 3'd1;
   localparam logic [OP_W-1:0] OP_ERASE_DISP = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE_LINE = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
   localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;

   // Erase modes.
   localparam logic [MODE_W-1:0] MODE_TO_END     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FROM_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALL        = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE       = 2'd3;

   // Finished result handed from the sequencer to the output stage.
   typedef struct packed {
      logic              valid;
      logic [CELL_W-1:0] read_value;
      logic              clamped;
   } result_type;

   // Cell store access issued by the sequencer.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

// ----- hw/rtl/text_screen_edit_engine.sv -----
// Text screen edit engine: a ROWS x COLUMNS character store with VT100-style edits.
// Each transaction is decoded in a setup step; a write is done there, a read then waits for the
// registered read data, an erase blanks its cells one at a time, and insert or delete moves whole
// rows cell by cell (a read, then a write), if any stay on screen, and then blanks the freed rows.
// One transaction is in work at a time; the next is taken once its result is in the output register.
// Reset: the store is cleared to spaces with req_tready low; rsp_tvalid resets low.
module text_screen_edit_engine
   import tse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] operation, [6:3] cursor_row, [11:7] cursor_col, [13:12] erase_mode,
   // [18:14] line_count, [26:19] cell_value, [31:27] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] read_value, [8] count_clamped, [15:9] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   result_type        result;
   logic              result_ready;
   ram_req_type       ram_req;
   logic [CELL_W-1:0] ram_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_clamp_ff, rsp_clamp_in;

   tse_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_operation  (req_tdata[2:0]),
      .req_cursor_row (req_tdata[6:3]),
      .req_cursor_col (req_tdata[11:7]),
      .req_erase_mode (req_tdata[13:12]),
      .req_line_count (req_tdata[18:14]),
      .req_cell_value (req_tdata[26:19]),
      .result         (result),
      .result_ready   (result_ready),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data)
   );

   tse_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: loads when empty or being drained.
   always_comb begin
      result_ready = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_clamp_in = rsp_clamp_ff;
      if (result.valid && result_ready) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result.read_value;
         rsp_clamp_in = result.clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_clamp_ff <= rsp_clamp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CELL_W - 1){1'b0}}, rsp_clamp_ff, rsp_value_ff};

endmodule

// ----- hw/rtl/tse_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; width and depth come from its parameters.
module tse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tse_ctrl.sv -----
// Sequencer of the text screen edit engine: walks the cell store one cell per step
// with a shared row/column stepper for clears, erases, row copies and blanking.
// Depends on tse_pkg.
module tse_ctrl
   import tse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [IN_ROW_W-1:0] req_cursor_row,
   input  logic [IN_COL_W-1:0] req_cursor_col,
   input  logic [MODE_W-1:0]   req_erase_mode,
   input  logic [IN_CNT_W-1:0] req_line_count,
   input  logic [CELL_W-1:0]   req_cell_value,
   output result_type          result,
   input  logic                result_ready,
   output ram_req_type         ram_req,
   input  logic [CELL_W-1:0]   ram_rd_data
);

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_SETUP   = 8'b0000_0100,
      S_RDWAIT  = 8'b0000_1000,
      S_COPY_RD = 8'b0001_0000,
      S_COPY_WR = 8'b0010_0000,
      S_BLANK   = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              clamp_ff, clamp_in;
   logic              copy_ff, copy_in;
   logic [CELL_W-1:0] value_ff, value_in;
   logic [CELL_W-1:0] rdval_ff, rdval_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  end_row_ff, end_row_in;
   logic [COL_W-1:0]  end_col_ff, end_col_in;
   logic              desc_ff, desc_in;
   logic [ROW_W-1:0]  bfirst_ff, bfirst_in;
   logic [ROW_W-1:0]  blast_ff, blast_in;

   logic [ROW_W-1:0]  sat_row;
   logic [COL_W-1:0]  sat_col;
   logic [CNT_W-1:0]  room;
   logic              at_end;
   logic [ROW_W-1:0]  next_row;
   logic [COL_W-1:0]  next_col;
   logic [ROW_W-1:0]  src_row;

   // Cursor saturation and line count clamp for an incoming transaction.
   always_comb begin
      sat_row = (int'(req_cursor_row) >= ROWS) ? LAST_ROW : ROW_W'(req_cursor_row);
      sat_col = (int'(req_cursor_col) >= COLUMNS) ? LAST_COL : COL_W'(req_cursor_col);
      room    = CNT_W'(ROWS) - CNT_W'(sat_row);
   end

   // Shared stepper: position compare, forward step with row wrap, and source row of a copy.
   always_comb begin
      at_end   = (cur_row_ff == end_row_ff) && (cur_col_ff == end_col_ff);
      next_col = (cur_col_ff == LAST_COL) ? '0 : COL_W'(cur_col_ff + 1'b1);
      next_row = (cur_col_ff == LAST_COL) ? ROW_W'(cur_row_ff + 1'b1) : cur_row_ff;
      src_row  = desc_ff ? ROW_W'(CNT_W'(cur_row_ff) - n_ff)
                         : ROW_W'(CNT_W'(cur_row_ff) + n_ff);
   end

   // Sequencer next-state and datapath.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      mode_in    = mode_ff;
      n_in       = n_ff;
      clamp_in   = clamp_ff;
      copy_in    = copy_ff;
      value_in   = value_ff;
      rdval_in   = rdval_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      end_row_in = end_row_ff;
      end_col_in = end_col_ff;
      desc_in    = desc_ff;
      bfirst_in  = bfirst_ff;
      blast_in   = blast_ff;

      ram_req         = '0;
      ram_req.wr_data = BLANK;

      req_ready  = (state_ff == S_IDLE);
      result.valid      = (state_ff == S_DONE);
      result.read_value = rdval_ff;
      result.clamped    = clamp_ff;

      case (state_ff)
         // Power-up pass that fills every cell with a blank.
         S_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = {cur_row_ff, cur_col_ff};
            cur_row_in      = next_row;
            cur_col_in      = next_col;
            if (at_end) begin
               state_in = S_IDLE;
            end
         end
         // Take a transaction and latch its fields.
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               row_in   = sat_row;
               col_in   = sat_col;
               mode_in  = req_erase_mode;
               value_in = req_cell_value;
               rdval_in = '0;
               clamp_in = ((req_operation == OP_INSERT) || (req_operation == OP_DELETE)) &&
                          (int'(req_line_count) > int'(room));
               n_in     = (int'(req_line_count) > int'(room)) ? room : CNT_W'(req_line_count);
               copy_in  = (int'(req_line_count) < int'(room));
               state_in = S_SETUP;
            end
         end
         // Decode the operation and load the stepper.
         S_SETUP: begin
            state_in = S_DONE;
            case (op_ff)
               OP_WRITE: begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = {row_ff, col_ff};
                  ram_req.wr_data = value_ff;
               end
               OP_READ: begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = {row_ff, col_ff};
                  state_in        = S_RDWAIT;
               end
               OP_ERASE_DISP, OP_ERASE_LINE: begin
                  cur_row_in = row_ff;
                  cur_col_in = '0;
                  end_row_in = row_ff;
                  end_col_in = LAST_COL;
                  case (mode_ff)
                     MODE_TO_END: begin
                        cur_col_in = col_ff;
                        if (op_ff == OP_ERASE_DISP) begin
                           end_row_in = LAST_ROW;
                        end
                     end
                     MODE_FROM_START: begin
                        end_col_in = col_ff;
                        if (op_ff == OP_ERASE_DISP) begin
                           cur_row_in = '0;
                        end
                     end
                     MODE_ALL: begin
                        if (op_ff == OP_ERASE_DISP) begin
                           cur_row_in = '0;
                           end_row_in = LAST_ROW;
                        end
                     end
                     default: begin
                        cur_row_in = cur_row_ff;
                     end
                  endcase
                  if (mode_ff != MODE_NONE) begin
                     state_in = S_BLANK;
                  end
               end
               OP_INSERT, OP_DELETE: begin
                  if (op_ff == OP_INSERT) begin
                     bfirst_in  = row_ff;
                     blast_in   = ROW_W'(CNT_W'(row_ff) + n_ff - 1'b1);
                     desc_in    = 1'b1;
                     cur_row_in = LAST_ROW;
                     end_row_in = ROW_W'(CNT_W'(row_ff) + n_ff);
                  end else begin
                     bfirst_in  = ROW_W'(CNT_W'(ROWS) - n_ff);
                     blast_in   = LAST_ROW;
                     desc_in    = 1'b0;
                     cur_row_in = row_ff;
                     end_row_in = ROW_W'(CNT_W'(ROWS - 1) - n_ff);
                  end
                  cur_col_in = '0;
                  end_col_in = LAST_COL;
                  if (n_ff != '0) begin
                     if (copy_ff) begin
                        state_in = S_COPY_RD;
                     end else begin
                        cur_row_in = bfirst_in;
                        end_row_in = blast_in;
                        state_in   = S_BLANK;
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         // Registered read data of a cell read.
         S_RDWAIT: begin
            rdval_in = ram_rd_data;
            state_in = S_DONE;
         end
         // Row move: read the source cell.
         S_COPY_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = {src_row, cur_col_ff};
            state_in        = S_COPY_WR;
         end
         // Row move: write the destination cell, then step.
         S_COPY_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = {cur_row_ff, cur_col_ff};
            ram_req.wr_data = ram_rd_data;
            cur_col_in      = next_col;
            state_in        = S_COPY_RD;
            if (cur_col_ff == LAST_COL) begin
               if (cur_row_ff == end_row_ff) begin
                  cur_row_in = bfirst_ff;
                  end_row_in = blast_ff;
                  end_col_in = LAST_COL;
                  state_in   = S_BLANK;
               end else if (desc_ff) begin
                  cur_row_in = ROW_W'(cur_row_ff - 1'b1);
               end else begin
                  cur_row_in = ROW_W'(cur_row_ff + 1'b1);
               end
            end
         end
         // Blank one cell per cycle up to the end position.
         S_BLANK: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = {cur_row_ff, cur_col_ff};
            cur_row_in      = next_row;
            cur_col_in      = next_col;
            if (at_end) begin
               state_in = S_DONE;
            end
         end
         // Hand the result to the output stage.
         S_DONE: begin
            if (result_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         end_row_ff <= LAST_ROW;
         end_col_ff <= LAST_COL;
      end else begin
         state_ff   <= state_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         end_row_ff <= end_row_in;
         end_col_ff <= end_col_in;
      end
   end

   // Transaction payload and walk bounds.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      mode_ff   <= mode_in;
      n_ff      <= n_in;
      clamp_ff  <= clamp_in;
      copy_ff   <= copy_in;
      value_ff  <= value_in;
      rdval_ff  <= rdval_in;
      desc_ff   <= desc_in;
      bfirst_ff <= bfirst_in;
      blast_ff  <= blast_in;
   end

endmodule

// ----- hw/rtl/tse_checker.sv -----
// Port-level checker of the text screen edit engine, bound to the top level.
// Depends on tse_pkg and text_screen_edit_engine.
module tse_checker
   import tse_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result transaction changed while stalled");

   // The block works on one transaction at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // The clearing pass after reset blocks requests and no result is pending.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block not quiet after reset");

   // Unused result bits stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:CELL_W+1] == '0)
      else $error("result padding not zero");

endmodule

bind text_screen_edit_engine tse_checker u_tse_checker (.*);
